/* sv/plid_pkg.sv */
// Shared types and codes for the positional list block.
// Holds the operation kinds, result status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package plid_pkg;

   typedef enum logic [2:0] {
      KIND_LOAD    = 3'd0,
      KIND_READOUT = 3'd1,
      KIND_INSERT  = 3'd2,
      KIND_UPDATE  = 3'd3,
      KIND_DELETE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_BADIDX = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_EMIT      = 5'b00010,
      ST_MOVE      = 5'b00100,
      ST_WRITE_NEW = 5'b01000,
      ST_FINISH    = 5'b10000
   } state_type;

endpackage

/* sv/plid_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module plid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds until the next read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/plid_step.sv */
// Address stepping unit shared by readout, insert and delete sweeps.
// Produces the next source address, the move destination and the end compare.
// No dependencies.
`timescale 1ns / 1ps

module plid_step #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic [AW-1:0] ptr,
   input  logic          down,
   input  logic [AW-1:0] stop,
   output logic [AW-1:0] next,
   output logic [AW-1:0] dst,
   output logic          at_end
);

   logic [AW-1:0] ptr_inc;
   logic [AW-1:0] ptr_dec;

   assign ptr_inc = ptr + AW'(1);
   assign ptr_dec = ptr - AW'(1);

   // A downward sweep (insert) reads lower and writes one above the source.
   assign next   = down ? ptr_dec : ptr_inc;
   assign dst    = down ? ptr_inc : ptr_dec;
   assign at_end = (ptr == stop);

endmodule

/* sv/positional_list_insert_delete_top.sv */
// Positional list top level: ordered list storage, sweep sequencer, output register.
// Depends on plid_pkg, plid_ram and plid_step.
`timescale 1ns / 1ps

// The block keeps an ordered list of up to DEPTH signed words and its length,
// and works on one request word at a time; req_stall is high while a request is
// in progress. A readout emits one response word per cycle while the response
// side keeps up. An insert or a delete moves the later elements one per cycle
// through the single read and single write port of the element memory, with
// the shared address stepper picking the next source and destination. A
// stalled response side stretches the closing cycle of every answered request
// until its word can enter the output register. Responses sit in an output
// register, so a new request is taken while the last response still waits.
// Reset empties the list at once; the element memory itself needs no clearing
// because only positions below the length are ever read.

module positional_list_insert_delete_top #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_index,
   input  logic               req_first_of_load,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic [5:0]         rsp_position,
   output logic [6:0]         rsp_count,
   output logic               rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   // Sequencer and list state.
   plid_pkg::state_type  state_ff, state_in;
   logic [LW-1:0]        length_ff, length_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        stop_ff, stop_in;
   logic                 down_ff, down_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [WIDTH-1:0]     value_ff, value_in;
   plid_pkg::status_type status_ff, status_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic signed [31:0]   rsp_element_ff, rsp_element_in;
   logic [5:0]           rsp_position_ff, rsp_position_in;
   logic [6:0]           rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WIDTH-1:0]     wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WIDTH-1:0]     rd_data;

   // Stepper results.
   logic [AW-1:0]        step_next;
   logic [AW-1:0]        step_dst;
   logic                 step_at_end;

   logic                 req_accept;
   logic                 out_free;
   logic                 out_load;
   logic [LW-1:0]        len0;
   logic [LW-1:0]        len_m1;
   logic [6:0]           len7;
   logic [6:0]           idx_p1;
   logic [WIDTH-1:0]     req_word;

   plid_ram #(
      .WIDTH(WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   plid_step #(
      .DEPTH(DEPTH)
   ) u_step (
      .ptr   (ptr_ff),
      .down  (down_ff),
      .stop  (stop_ff),
      .next  (step_next),
      .dst   (step_dst),
      .at_end(step_at_end)
   );

   assign req_stall  = (state_ff != plid_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // The value is sign-extended or truncated to the stored word width.
   assign req_word = WIDTH'(req_value);
   assign len0     = req_first_of_load ? '0 : length_ff;
   assign len_m1   = length_ff - LW'(1);
   assign len7     = 7'(length_ff);
   assign idx_p1   = req_index + 7'd1;

   always_comb begin
      state_in        = state_ff;
      length_in       = length_ff;
      ptr_in          = ptr_ff;
      stop_in         = stop_ff;
      down_in         = down_ff;
      idx_in          = idx_ff;
      value_in        = value_ff;
      status_in       = status_ff;
      wr_en           = 1'b0;
      wr_addr         = step_dst;
      wr_data         = rd_data;
      rd_en           = 1'b0;
      rd_addr         = step_next;
      out_load        = 1'b0;
      rsp_status_in   = plid_pkg::STATUS_OK;
      rsp_element_in  = '0;
      rsp_position_in = '0;
      rsp_count_in    = len7;
      rsp_last_in     = 1'b1;

      unique case (state_ff)
         plid_pkg::ST_IDLE: begin
            if (req_accept) begin
               idx_in    = req_index[AW-1:0];
               value_in  = req_word;
               status_in = plid_pkg::STATUS_OK;
               unique case (plid_pkg::kind_type'(req_kind))
                  plid_pkg::KIND_LOAD: begin
                     state_in = plid_pkg::ST_FINISH;
                     if (len0 >= LW'(DEPTH)) begin
                        status_in = plid_pkg::STATUS_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = len0[AW-1:0];
                        wr_data   = req_word;
                        length_in = len0 + LW'(1);
                     end
                  end
                  plid_pkg::KIND_READOUT: begin
                     if (length_ff == '0) begin
                        status_in = plid_pkg::STATUS_EMPTY;
                        state_in  = plid_pkg::ST_FINISH;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        ptr_in   = '0;
                        stop_in  = len_m1[AW-1:0];
                        down_in  = 1'b0;
                        state_in = plid_pkg::ST_EMIT;
                     end
                  end
                  plid_pkg::KIND_INSERT: begin
                     if (length_ff >= LW'(DEPTH)) begin
                        status_in = plid_pkg::STATUS_FULL;
                        state_in  = plid_pkg::ST_FINISH;
                     end else if (req_index > len7) begin
                        status_in = plid_pkg::STATUS_BADIDX;
                        state_in  = plid_pkg::ST_FINISH;
                     end else if (req_index == len7) begin
                        state_in = plid_pkg::ST_WRITE_NEW;
                     end else begin
                        // Move the tail up, starting from the last element.
                        rd_en    = 1'b1;
                        rd_addr  = len_m1[AW-1:0];
                        ptr_in   = len_m1[AW-1:0];
                        stop_in  = req_index[AW-1:0];
                        down_in  = 1'b1;
                        state_in = plid_pkg::ST_MOVE;
                     end
                  end
                  plid_pkg::KIND_UPDATE: begin
                     state_in = plid_pkg::ST_FINISH;
                     if (req_index < len7) begin
                        wr_en   = 1'b1;
                        wr_addr = req_index[AW-1:0];
                        wr_data = req_word;
                     end else begin
                        status_in = plid_pkg::STATUS_BADIDX;
                     end
                  end
                  plid_pkg::KIND_DELETE: begin
                     if (req_index >= len7) begin
                        status_in = plid_pkg::STATUS_BADIDX;
                        state_in  = plid_pkg::ST_FINISH;
                     end else if (idx_p1 == len7) begin
                        length_in = len_m1;
                        state_in  = plid_pkg::ST_FINISH;
                     end else begin
                        // Move the tail down, starting just past the hole.
                        rd_en    = 1'b1;
                        rd_addr  = idx_p1[AW-1:0];
                        ptr_in   = idx_p1[AW-1:0];
                        stop_in  = len_m1[AW-1:0];
                        down_in  = 1'b0;
                        state_in = plid_pkg::ST_MOVE;
                     end
                  end
                  default: begin
                     // Unused kind codes are taken and dropped without a response.
                  end
               endcase
            end
         end
         plid_pkg::ST_EMIT: begin
            if (out_free) begin
               out_load        = 1'b1;
               rsp_element_in  = 32'(signed'(rd_data));
               rsp_position_in = 6'(ptr_ff);
               rsp_last_in     = step_at_end;
               if (step_at_end) begin
                  state_in = plid_pkg::ST_IDLE;
               end else begin
                  rd_en  = 1'b1;
                  ptr_in = step_next;
               end
            end
         end
         plid_pkg::ST_MOVE: begin
            // The word read last cycle lands one slot away from its source.
            wr_en = 1'b1;
            if (step_at_end) begin
               if (down_ff) begin
                  state_in = plid_pkg::ST_WRITE_NEW;
               end else begin
                  length_in = len_m1;
                  state_in  = plid_pkg::ST_FINISH;
               end
            end else begin
               rd_en  = 1'b1;
               ptr_in = step_next;
            end
         end
         plid_pkg::ST_WRITE_NEW: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = value_ff;
            length_in = length_ff + LW'(1);
            state_in  = plid_pkg::ST_FINISH;
         end
         plid_pkg::ST_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = status_ff;
               state_in      = plid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plid_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plid_pkg::ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      stop_ff   <= stop_in;
      down_ff   <= down_in;
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      if (out_load) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_element_ff  <= rsp_element_in;
         rsp_position_ff <= rsp_position_in;
         rsp_count_ff    <= rsp_count_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

/* sv/plid_checker.sv */
// Port-level checks for the positional list block, bound to its top level.
// Depends on plid_pkg and positional_list_insert_delete_top.
`timescale 1ns / 1ps

module plid_checker #(
   parameter int DEPTH = 64
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_element,
   input logic [5:0]         rsp_position,
   input logic [6:0]         rsp_count,
   input logic               rsp_last
);

   // A held response word keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element) && $stable(rsp_count)
         && $stable(rsp_position) && $stable(rsp_last) && $stable(rsp_status))
      else $error("stalled response word changed");

   // The reported length never exceeds the list capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= 7'(DEPTH))
      else $error("response count above capacity");

   // An empty readout is a single closing word with no elements.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == plid_pkg::STATUS_EMPTY |-> rsp_count == '0 && rsp_last)
      else $error("empty status with nonzero count or not last");

   // Any error-status word carries no element and closes its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != plid_pkg::STATUS_OK |->
         rsp_element == '0 && rsp_position == '0 && rsp_last)
      else $error("error status word carries element data");

   // An emitted position other than zero lies inside the list, and the last one closes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position != '0 |->
         (7'(rsp_position) < rsp_count) && (rsp_last == (7'(rsp_position) + 7'd1 == rsp_count)))
      else $error("readout position outside list or misplaced last");

endmodule

bind positional_list_insert_delete_top plid_checker #(.DEPTH(DEPTH)) u_plid_checker (.*);
